// ===== rtl/core/sm3_pkg.sv =====
package sm3_pkg;

	localparam logic [31:0] TJ_LOW  = 32'h79CC4519;
	localparam logic [31:0] TJ_HIGH = 32'h7A879D8A;
	localparam logic [7:0]  PAD_BYTE = 8'h80;
	localparam int unsigned WORDS = 8;
	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned ROUNDS = 64;

	typedef logic [31:0] word_t;
	typedef word_t [7:0] state_t;

	localparam state_t IV = '{
		32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
		32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
	};

	// byte source for the block register
	typedef enum logic [1:0] {
		SRC_MSG,
		SRC_PAD,
		SRC_ZERO,
		SRC_LEN
	} byte_src_t;

	// controller to datapath
	typedef struct packed {
		logic      wr_byte;
		byte_src_t src;
		logic      start_round;
		logic      round_en;
		logic      fold;
		logic      add_block_len;
		logic      latch_total;
		logic      restart;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [5:0] fill;
		logic [5:0] round;
	} dp_status_t;

	function automatic word_t rotl(input word_t x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic word_t perm0(input word_t x);
		return x ^ {x[22:0], x[31:23]} ^ {x[14:0], x[31:15]};
	endfunction

	function automatic word_t perm1(input word_t x);
		return x ^ {x[16:0], x[31:17]} ^ {x[8:0], x[31:9]};
	endfunction

endpackage

// ===== rtl/core/sm3_stream_if.sv =====
interface sm3_stream_if #(parameter int unsigned W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/sm3_datapath.sv =====
module sm3_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  sm3_pkg::dp_cmd_t    cmd,
	input  logic [7:0]          msg_byte,
	input  logic [2:0]          out_idx,
	output sm3_pkg::dp_status_t status,
	output sm3_pkg::word_t      out_word
);
	logic [5:0]          fill_q;
	logic [5:0]          round_q;
	logic [63:0]         bit_length_q;
	logic [63:0]         total_q;
	sm3_pkg::state_t     cv_q;
	sm3_pkg::state_t     wk_q;
	sm3_pkg::state_t     wk_next;
	sm3_pkg::word_t [15:0] w_q;
	logic [7:0]          byte_in;
	sm3_pkg::word_t      a, b, c, d, e, f, g, h, a12, ss1, ss2, fv, gv, tt1, tt2, tj, wn;

	assign status.fill = fill_q;
	assign status.round = round_q;
	assign out_word = cv_q[out_idx];

	// byte mux, length bytes taken big-endian from the low fill bits
	always_comb begin
		byte_in = msg_byte;
		case (cmd.src)
			sm3_pkg::SRC_MSG:  byte_in = msg_byte;
			sm3_pkg::SRC_PAD:  byte_in = sm3_pkg::PAD_BYTE;
			sm3_pkg::SRC_ZERO: byte_in = 8'h00;
			sm3_pkg::SRC_LEN:  byte_in = total_q[8'(7 - fill_q[2:0]) * 8 +: 8];
			default:           byte_in = msg_byte;
		endcase
	end

	// one compression round, message words slide through a 16-word window
	always_comb begin
		{h, g, f, e, d, c, b, a} = wk_q;
		tj = (round_q < 6'd16) ? sm3_pkg::TJ_LOW : sm3_pkg::TJ_HIGH;
		a12 = sm3_pkg::rotl(a, 5'd12);
		ss1 = sm3_pkg::rotl(a12 + e + sm3_pkg::rotl(tj, round_q[4:0]), 5'd7);
		ss2 = ss1 ^ a12;
		if (round_q < 6'd16) begin
			fv = a ^ b ^ c;
			gv = e ^ f ^ g;
		end else begin
			fv = (a & b) | (a & c) | (b & c);
			gv = (e & f) | (~e & g);
		end
		wn = sm3_pkg::perm1(w_q[0] ^ w_q[7] ^ sm3_pkg::rotl(w_q[13], 5'd15)) ^
			sm3_pkg::rotl(w_q[3], 5'd7) ^ w_q[10];
		tt1 = fv + d + ss2 + (w_q[0] ^ w_q[4]);
		tt2 = gv + h + ss1 + w_q[0];
		wk_next = {g, sm3_pkg::rotl(f, 5'd19), e, sm3_pkg::perm0(tt2),
			c, sm3_pkg::rotl(b, 5'd9), a, tt1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			round_q <= '0;
			bit_length_q <= '0;
			cv_q <= sm3_pkg::IV;
		end else begin
			if (cmd.wr_byte) fill_q <= fill_q + 6'd1;
			if (cmd.start_round) round_q <= '0;
			else if (cmd.round_en) round_q <= round_q + 6'd1;
			if (cmd.add_block_len) bit_length_q <= bit_length_q + 64'd512;
			// fold in the output of the last round
			if (cmd.fold) cv_q <= cv_q ^ wk_next;
			if (cmd.restart) begin
				fill_q <= '0;
				bit_length_q <= '0;
				cv_q <= sm3_pkg::IV;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch_total) total_q <= bit_length_q + {55'd0, fill_q, 3'd0};
		if (cmd.wr_byte) w_q[fill_q[5:2]][8'(3 - fill_q[1:0]) * 8 +: 8] <= byte_in;
		if (cmd.start_round) wk_q <= cv_q;
		else if (cmd.round_en) begin
			wk_q <= wk_next;
			w_q <= {wn, w_q[15:1]};
		end
	end
endmodule

// ===== rtl/core/sm3_ctrl.sv =====
module sm3_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_present,
	input  logic                in_end,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          out_idx,
	input  sm3_pkg::dp_status_t status,
	output sm3_pkg::dp_cmd_t    cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_COMP, S_PAD, S_ZERO, S_LEN, S_OUT
	} state_t;

	state_t state_q;
	logic   final_q;  // message ended, pad byte still to be written
	logic   last_q;   // block now compressing holds the length
	logic   pad_q;    // block now compressing is the first of two padding blocks

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		cmd.src = sm3_pkg::SRC_MSG;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_present) cmd.wr_byte = 1'b1;
				if (in_valid && in_present && status.fill == 6'd63) begin
					cmd.start_round = 1'b1;
					cmd.add_block_len = 1'b1;
				end
			end
			S_COMP: begin
				cmd.round_en = 1'b1;
				if (status.round == 6'd63) cmd.fold = 1'b1;
			end
			S_PAD: begin
				cmd.wr_byte = 1'b1;
				cmd.src = sm3_pkg::SRC_PAD;
				// first padding cycle: length from the counted bytes
				cmd.latch_total = final_q;
				if (status.fill == 6'd63) cmd.start_round = 1'b1;
			end
			S_ZERO: begin
				cmd.wr_byte = 1'b1;
				cmd.src = sm3_pkg::SRC_ZERO;
				if (status.fill == 6'd63) cmd.start_round = 1'b1;
			end
			S_LEN: begin
				cmd.wr_byte = 1'b1;
				cmd.src = sm3_pkg::SRC_LEN;
				if (status.fill == 6'd63) cmd.start_round = 1'b1;
			end
			S_OUT: if (out_ready && out_idx == 3'd7) cmd.restart = 1'b1;
			default: ;
		endcase
	end

	// state, padding flags and digest word index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			final_q <= 1'b0;
			last_q <= 1'b0;
			pad_q <= 1'b0;
			out_idx <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					if (in_present && status.fill == 6'd63) begin
						state_q <= S_COMP;
						final_q <= in_end;
						last_q <= 1'b0;
						pad_q <= 1'b0;
					end else if (in_end) begin
						state_q <= S_PAD;
						final_q <= 1'b1;
					end
				end
				S_COMP: if (status.round == 6'd63) begin
					if (last_q) begin
						state_q <= S_OUT;
						out_idx <= '0;
					end else if (final_q) state_q <= S_PAD;
					else if (pad_q) state_q <= S_ZERO;
					else state_q <= S_IDLE;
				end
				S_PAD: begin
					final_q <= 1'b0;
					if (status.fill == 6'd63) begin
						state_q <= S_COMP;
						last_q <= 1'b0;
						pad_q <= 1'b1;
					end else if (status.fill == 6'd55) state_q <= S_LEN;
					else state_q <= S_ZERO;
				end
				S_ZERO: if (status.fill == 6'd63) begin
					state_q <= S_COMP;
					last_q <= 1'b0;
					pad_q <= 1'b1;
				end else if (status.fill == 6'd55) state_q <= S_LEN;
				S_LEN: if (status.fill == 6'd63) begin
					state_q <= S_COMP;
					last_q <= 1'b1;
					pad_q <= 1'b0;
				end
				S_OUT: if (out_ready) begin
					out_idx <= out_idx + 3'd1;
					if (out_idx == 3'd7) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_len_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LEN) |-> (status.fill >= 6'd56))
		else $error("length bytes outside tail");
	a_out_after_comp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == S_COMP && out_idx == 3'd0))
		else $error("digest not after compression");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMP) |-> !in_ready)
		else $error("accept during compression");
endmodule

// ===== rtl/core/sm3_hash_engine.sv =====
// SM3 hash engine.
// Input channel carries one word per item: {end_of_message, byte_present, msg_byte}.
// An accepted byte goes into the block register; the 64th byte of a block starts 64
// compression rounds, one per cycle, during which no input is taken.
// A final item closes the message: the padding byte, zeros and the 64-bit
// length are written one per cycle into the block register, then compressed; a
// second block is needed when the final fill leaves fewer than 9 bytes. All 64
// rounds use one shared round unit; the block register has a one-byte write port.
// Output channel then gives eight digest words, word 0 most significant,
// last_word marks word 7. A stalled receiver holds the current word and
// the engine waits; input stays blocked until word 7 is taken, after which
// the chaining value returns to the initial vector.
// Reset clears the chaining value to the initial vector and the counters.
module sm3_hash_engine (
	input logic clk,
	input logic arst_n,
	sm3_stream_if.sink   in_ch,
	sm3_stream_if.source out_ch
);
	sm3_pkg::dp_cmd_t    cmd;
	sm3_pkg::dp_status_t status;
	logic [2:0]          out_idx;
	sm3_pkg::word_t      out_word;

	sm3_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_present(in_ch.data[8]), .in_end(in_ch.data[9]),
		.in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_idx(out_idx),
		.status(status), .cmd(cmd)
	);

	sm3_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .msg_byte(in_ch.data[7:0]),
		.out_idx(out_idx), .status(status), .out_word(out_word)
	);

	assign out_ch.data = {(out_idx == 3'd7), out_idx, out_word};
endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	localparam int unsigned IDLE_LIMIT = 6000;
	localparam int unsigned HOLD_CYCLES = 700;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_word_t;

	logic clk;
	logic arst_n;

	sm3_stream_if #(.W(10)) in_if ();
	sm3_stream_if #(.W(36)) out_if ();

	sm3_hash_engine uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if.sink),
		.out_ch (out_if.source)
	);

	// predictor state
	logic [31:0] chain[8];
	logic [7:0]  block_bytes[64];
	int unsigned fill;
	logic [63:0] bit_count;

	digest_word_t digest_q[$];
	int unsigned errors;
	int unsigned burst_left;
	int unsigned hold_left;
	logic        hold_req;
	int unsigned idle_count;

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [31:0] rol(logic [31:0] x, int unsigned n);
		n = n % 32;
		if (n == 0)
			return x;
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [31:0] mix0(logic [31:0] x);
		return x ^ rol(x, 9) ^ rol(x, 17);
	endfunction

	function automatic logic [31:0] mix1(logic [31:0] x);
		return x ^ rol(x, 15) ^ rol(x, 23);
	endfunction

	// one compression of block_bytes into chain
	task automatic compress();
		logic [31:0] w[68];
		logic [31:0] a, b, c, d, e, f, g, h;
		logic [31:0] tj, a12, ss1, ss2, fv, gv, tt1, tt2;
		begin
			for (int j = 0; j < 16; j++)
				w[j] = {block_bytes[4*j], block_bytes[4*j+1], block_bytes[4*j+2],
					block_bytes[4*j+3]};
			for (int j = 16; j < 68; j++)
				w[j] = mix1(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
			a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
			e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
			for (int j = 0; j < 64; j++) begin
				tj = (j < 16) ? 32'h79CC4519 : 32'h7A879D8A;
				a12 = rol(a, 12);
				ss1 = rol(a12 + e + rol(tj, j), 7);
				ss2 = ss1 ^ a12;
				if (j < 16) begin
					fv = a ^ b ^ c;
					gv = e ^ f ^ g;
				end else begin
					fv = (a & b) | (a & c) | (b & c);
					gv = (e & f) | (~e & g);
				end
				tt1 = fv + d + ss2 + (w[j] ^ w[j+4]);
				tt2 = gv + h + ss1 + w[j];
				d = c; c = rol(b, 9); b = a; a = tt1;
				h = g; g = rol(f, 19); f = e; e = mix0(tt2);
			end
			chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
			chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
		end
	endtask

	task automatic restart_hash();
		begin
			for (int i = 0; i < 8; i++)
				chain[i] = sm3_pkg::IV[i];
			fill = 0;
			bit_count = '0;
		end
	endtask

	// absorb one accepted word, queue the digest on a final word
	task automatic predict_digest(logic [7:0] data, logic present, logic eom);
		int unsigned pos;
		logic [63:0] total;
		digest_word_t dw;
		begin
			if (present) begin
				block_bytes[fill] = data;
				fill++;
				if (fill == 64) begin
					compress();
					bit_count += 64'd512;
					fill = 0;
				end
			end
			if (eom) begin
				pos = fill;
				total = bit_count + 64'(pos) * 64'd8;
				block_bytes[pos] = sm3_pkg::PAD_BYTE;
				pos++;
				if (pos > 56) begin
					while (pos < 64) begin
						block_bytes[pos] = 8'h00;
						pos++;
					end
					compress();
					pos = 0;
				end
				while (pos < 56) begin
					block_bytes[pos] = 8'h00;
					pos++;
				end
				for (int i = 0; i < 8; i++)
					block_bytes[56+i] = total[63-8*i -: 8];
				compress();
				for (int i = 0; i < 8; i++) begin
					dw.word = chain[i];
					dw.index = 3'(i);
					dw.last = (i == 7);
					digest_q.push_back(dw);
				end
				restart_hash();
			end
		end
	endtask

	task automatic report(string what, logic [35:0] want, logic [35:0] got);
		begin
			$display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
			errors++;
		end
	endtask

	// send one word, in bursts with random gaps
	task automatic send_word(logic [7:0] data, logic present, logic eom);
		int unsigned gap;
		begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0) begin
					in_if.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			in_if.valid <= 1'b1;
			in_if.data <= {eom, present, data};
			do
				@(posedge clk);
			while (!in_if.ready);
			predict_digest(data, present, eom);
			burst_left--;
		end
	endtask

	task automatic send_message(int unsigned len, bit empty_tail);
		begin
			for (int unsigned i = 0; i < len; i++)
				send_word(8'($urandom), 1'b1, (i == len - 1) && !empty_tail);
			if (len == 0 || empty_tail)
				send_word(8'($urandom), 1'b0, 1'b1);
		end
	endtask

	// receiver stall pattern and long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_if.ready <= 1'b0;
			hold_left <= 0;
		end else if (hold_req && hold_left == 0 && out_if.ready) begin
			hold_left <= HOLD_CYCLES;
			out_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_if.ready <= (hold_left == 1);
		end else if ((($time / 2000) % 3) == 0) begin
			out_if.ready <= 1'b1;
		end else begin
			out_if.ready <= ($urandom_range(0, 2) != 0);
		end
	end

	// digest checker
	always @(posedge clk) begin
		digest_word_t dw;
		logic [35:0]  want;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (digest_q.size() == 0) begin
				report("unexpected word", '0, out_if.data);
			end else begin
				dw = digest_q.pop_front();
				want = {dw.last, dw.index, dw.word};
				if (out_if.data[31:0] !== dw.word)
					report("digest_word", want, out_if.data);
				if (out_if.data[34:32] !== dw.index)
					report("word_index", want, out_if.data);
				if (out_if.data[35] !== dw.last)
					report("last_word", want, out_if.data);
			end
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if (!arst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count > IDLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	task automatic test_directed();
		begin
			// empty message, then the well known three-byte message
			send_word(8'h00, 1'b0, 1'b1);
			send_word(8'h61, 1'b1, 1'b0);
			send_word(8'h62, 1'b1, 1'b0);
			send_word(8'h63, 1'b1, 1'b1);
			// field extremes, ignored word in the middle
			send_word(8'h00, 1'b1, 1'b0);
			send_word(8'hA5, 1'b0, 1'b0);
			send_word(8'hFF, 1'b1, 1'b1);
			// message ending on the previous byte, closed by an empty word
			send_word(8'hFF, 1'b1, 1'b0);
			send_word(8'h00, 1'b1, 1'b0);
			send_word(8'h5A, 1'b0, 1'b1);
		end
	endtask

	task automatic test_padding_edges();
		int unsigned lens[4] = '{55, 56, 63, 64};
		begin
			foreach (lens[i])
				send_message(lens[i], 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic test_random(int unsigned budget);
		int unsigned sent;
		int unsigned len;
		begin
			sent = 0;
			while (sent < budget) begin
				if ($urandom_range(0, 15) == 0)
					send_word(8'($urandom), 1'b0, 1'b0);
				len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 12);
				send_message(len, $urandom_range(0, 3) == 0);
				sent += len + 1;
			end
		end
	endtask

	task automatic test_backpressure();
		begin
			// long receiver hold-off while the sender keeps going
			hold_req = 1'b1;
			send_message(3, 1'b0);
			hold_req = 1'b0;
			send_message(20, 1'b0);
			send_message(5, 1'b1);
			// sender drains completely before the next message
			in_if.valid <= 1'b0;
			burst_left = 0;
			wait (digest_q.size() == 0);
			@(posedge clk);
			send_message(9, 1'b0);
		end
	endtask

	initial begin
		errors = 0;
		burst_left = 0;
		hold_req = 1'b0;
		idle_count = 0;
		arst_n = 1'b0;
		in_if.valid = 1'b0;
		in_if.data = '0;
		restart_hash();
		for (int i = 0; i < 64; i++)
			block_bytes[i] = 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_padding_edges();
		test_backpressure();
		test_random(40);

		in_if.valid <= 1'b0;
		wait (digest_q.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

// ===== sm3_hash_engine.f =====
rtl/core/sm3_pkg.sv
rtl/core/sm3_stream_if.sv
rtl/core/sm3_datapath.sv
rtl/core/sm3_ctrl.sv
rtl/core/sm3_hash_engine.sv
sim/tb_top.sv
